### rtl/sme_pkg.sv
// Package for the stack machine execute block: opcodes, status codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package sme_pkg;
    localparam int STACK_DEPTH   = 4096;
    localparam int PROGRAM_DEPTH = 4096;
    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int IP_W   = 12;
    localparam int LEN_W  = 13;

    typedef enum logic [4:0] {
        OP_IN = 5'd0, OP_OUT = 5'd1, OP_ADD = 5'd2, OP_SUB = 5'd3, OP_MUL = 5'd4,
        OP_DIV = 5'd5, OP_MOD = 5'd6, OP_AND = 5'd7, OP_OR = 5'd8, OP_XOR = 5'd9,
        OP_NOT = 5'd10, OP_LNOT = 5'd11, OP_NEG = 5'd12, OP_SHR = 5'd13,
        OP_SHL = 5'd14, OP_JMP = 5'd15, OP_BR = 5'd16, OP_PUSH = 5'd17,
        OP_POP = 5'd18, OP_DUP = 5'd19, OP_RET = 5'd20
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2, ST_ASCII = 3'd3,
        ST_OPCODE = 3'd4, ST_IPRANGE = 3'd5, ST_DIVZERO = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_RDX, S_RDY, S_EXEC, S_DIV, S_DONE, S_OUT, S_HALT
    } t_state;

    localparam logic [LEN_W-1:0] PROG_LEN_RESET = LEN_W'(100);
endpackage

### rtl/stack_machine_execute.sv
// Stack machine execute unit: top level with sequencer, shared ALU and divider.
// Depends on sme_pkg and sme_ram.
//
//  channel  | dir | fields (low bit up)
//  s_axis   | in  | tdata: req_type[4:0], immediate[36:5], in_char[45:37]
//  m_axis   | out | tdata: next_ip[11:0], out_valid[12], out_char[19:13],
//           |     |        finished[20], return_value[52:21], status[55:53]
//  apb      | cfg | reg 0 program_length at 0x0
//
// An item runs from accept to accept through idle, read x, latch x and read y,
// latch y, execute/write. Errors found before the reads end an item early and halt.
// div and mod also pass through the shared bit-serial divider (32 steps, one exit).
// A result waits in the output register until taken while the next beat is taken;
// a new result holds in execute until the register frees.
// Reset is synchronous and clears control state; the stack RAM is not cleared.
`timescale 1ns / 1ps
module stack_machine_execute
    import sme_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // req_type, immediate, in_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // next_ip, out_valid, out_char, finished,
                                        // return_value, status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_state r_state, n_state;
    logic [LEN_W-1:0] r_plen;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IP_W-1:0]  r_ip, n_ip;
    logic [4:0]  r_op, n_op;
    logic [31:0] r_imm, n_imm;
    logic [8:0]  r_ch, n_ch;
    logic [31:0] r_x, n_x, r_y, n_y;
    logic [55:0] r_out, n_out;
    logic        r_oval, n_oval;
    // divider
    logic [31:0] r_q, n_q, r_rem, n_rem, r_dv, n_dv;
    logic [5:0]  r_dc, n_dc;
    logic        r_qneg, n_qneg, r_rneg, n_rneg;

    logic        ram_we;
    logic [SP_W-1:0] ram_addr;
    logic [31:0] ram_wdata, ram_rdata;

    sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    assign pready = 1'b1;
    assign prdata = {{(32-LEN_W){1'b0}}, r_plen};
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= PROG_LEN_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_plen <= pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ip    <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ip    <= n_ip;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_imm <= n_imm; r_ch <= n_ch; r_x <= n_x; r_y <= n_y;
        r_out <= n_out; r_q <= n_q; r_rem <= n_rem; r_dv <= n_dv; r_dc <= n_dc;
        r_qneg <= n_qneg; r_rneg <= n_rneg;
    end

    logic [12:0] limit;
    logic [1:0]  need;
    logic        grow, has_res, jump, is_div;
    logic [31:0] res, target;
    logic [2:0]  st;
    logic        ov;
    logic [6:0]  oc;
    logic        fin;
    logic        out_free;
    logic [32:0] dsub;
    logic [31:0] dividend_mag;

    function automatic logic [55:0] pack(input logic [IP_W-1:0] ip, input logic v,
                                         input logic [6:0] c, input logic f,
                                         input logic [31:0] rv, input logic [2:0] s);
        return {s, rv, f, c, v, ip};
    endfunction

    always_comb begin
        limit = (r_plen < 13'(PROGRAM_DEPTH)) ? r_plen : 13'(PROGRAM_DEPTH);
        case (r_op)
            OP_IN, OP_PUSH:            begin need = 2'd0; grow = 1'b1; end
            OP_DUP:                    begin need = 2'd1; grow = 1'b1; end
            OP_NOT, OP_LNOT, OP_NEG, OP_OUT, OP_JMP, OP_POP, OP_RET:
                                       begin need = 2'd1; grow = 1'b0; end
            default:                   begin need = 2'd2; grow = 1'b0; end
        endcase
        is_div = (r_op == OP_DIV) || (r_op == OP_MOD);
        out_free = !r_oval || m_axis_tready;
        dsub = {r_rem[30:0], r_q[31]} - {1'b0, r_dv};
        dividend_mag = '0;

        n_state = r_state; n_cnt = r_cnt; n_ip = r_ip; n_oval = r_oval;
        n_op = r_op; n_imm = r_imm; n_ch = r_ch; n_x = r_x; n_y = r_y;
        n_out = r_out; n_q = r_q; n_rem = r_rem; n_dv = r_dv; n_dc = r_dc;
        n_qneg = r_qneg; n_rneg = r_rneg;
        ram_we = 1'b0; ram_addr = SP_W'(r_cnt - 1'b1); ram_wdata = '0;
        res = '0; has_res = 1'b0; jump = 1'b0; target = 32'(r_ip) + 32'd1;
        st = ST_OK; ov = 1'b0; oc = '0; fin = 1'b0;

        if (r_oval && m_axis_tready) n_oval = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op = s_axis_tdata[4:0];
                    n_imm = s_axis_tdata[36:5];
                    n_ch = s_axis_tdata[45:37];
                    n_state = S_RDX;
                end
            end
            S_RDX: begin
                // check errors, then issue read of top
                if (13'(r_ip) >= limit) begin
                    st = ST_IPRANGE;
                end else if (r_op > OP_RET) begin
                    st = ST_OPCODE;
                end else if (r_cnt < CNT_W'(need)) begin
                    st = ST_UNDER;
                end else if (grow && r_cnt >= CNT_W'(STACK_DEPTH)) begin
                    st = ST_OVER;
                end
                if (st == ST_OK) begin
                    ram_addr = SP_W'(r_cnt - 1'b1);
                    n_state = S_RDY;
                end else if (out_free) begin
                    n_out = pack(r_ip, 1'b0, '0, 1'b0, '0, st);
                    n_state = S_OUT;
                end
            end
            S_RDY: begin
                // top arrives; issue read of the entry below
                n_x = ram_rdata;
                ram_addr = SP_W'(r_cnt - 2'd2);
                n_state = S_DIV;
            end
            S_DIV: begin
                // second entry arrives; set up the divider for div and mod
                n_y = ram_rdata;
                n_state = S_EXEC;
                if (is_div) begin
                    // y/x for div, x%y for mod
                    if (r_op == OP_DIV) begin
                        dividend_mag = ram_rdata[31] ? -ram_rdata : ram_rdata;
                        n_dv = r_x[31] ? -r_x : r_x;
                        n_qneg = ram_rdata[31] ^ r_x[31];
                        n_rneg = ram_rdata[31];
                    end else begin
                        dividend_mag = r_x[31] ? -r_x : r_x;
                        n_dv = ram_rdata[31] ? -ram_rdata : ram_rdata;
                        n_qneg = r_x[31] ^ ram_rdata[31];
                        n_rneg = r_x[31];
                    end
                    n_q = dividend_mag;
                    n_rem = '0;
                    n_dc = 6'd32;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // one restoring step per cycle
                if (r_dc != 6'd0) begin
                    if (!dsub[32]) begin
                        n_rem = dsub[31:0];
                        n_q = {r_q[30:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[30:0], r_q[31]};
                        n_q = {r_q[30:0], 1'b0};
                    end
                    n_dc = r_dc - 6'd1;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                has_res = 1'b1;
                case (r_op)
                    OP_IN:   res = {{23{r_ch[8]}}, r_ch};
                    OP_OUT: begin
                        if (r_x > 32'd127) st = ST_ASCII;
                        else begin ov = 1'b1; oc = r_x[6:0]; end
                        has_res = 1'b0;
                    end
                    OP_ADD:  res = r_x + r_y;
                    OP_SUB:  res = r_x - r_y;
                    OP_MUL:  res = r_x * r_y;
                    OP_DIV: begin
                        if (r_x == '0) st = ST_DIVZERO;
                        else res = r_qneg ? -r_q : r_q;
                    end
                    OP_MOD: begin
                        if (r_y == '0) st = ST_DIVZERO;
                        else res = r_rneg ? -r_rem : r_rem;
                    end
                    OP_AND:  res = r_x & r_y;
                    OP_OR:   res = r_x | r_y;
                    OP_XOR:  res = r_x ^ r_y;
                    OP_NOT:  res = ~r_x;
                    OP_LNOT: res = {31'd0, r_x == '0};
                    OP_NEG:  res = -r_x;
                    OP_SHR:  res = $signed(r_y) >>> r_x[4:0];
                    OP_SHL:  res = r_y << r_x[4:0];
                    OP_JMP: begin target = r_x; jump = 1'b1; has_res = 1'b0; end
                    OP_BR: begin
                        if (r_y != '0) begin target = r_x; jump = 1'b1; end
                        has_res = 1'b0;
                    end
                    OP_PUSH: res = r_imm;
                    OP_POP:  has_res = 1'b0;
                    OP_DUP:  res = r_x;
                    default: begin fin = 1'b1; has_res = 1'b0; end
                endcase
                // hold until the output register is free
                if (out_free) begin
                    if (st != ST_OK) begin
                        n_out = pack(r_ip, 1'b0, '0, 1'b0, '0, st);
                    end else begin
                        n_cnt = r_cnt - CNT_W'(need) + ((r_op == OP_DUP) ? 1'b1 : 1'b0);
                        if (has_res) begin
                            ram_we = 1'b1;
                            ram_addr = SP_W'(n_cnt);
                            ram_wdata = res;
                            n_cnt = n_cnt + 1'b1;
                        end
                        if (fin) begin
                            n_out = pack(r_ip, 1'b0, '0, 1'b1, r_x, ST_OK);
                            st = ST_IPRANGE; // forces halt below
                        end else if ((jump && target[31]) || target >= 32'(limit)) begin
                            n_out = pack(r_ip, ov, oc, 1'b0, '0, ST_IPRANGE);
                            st = ST_IPRANGE;
                        end else begin
                            n_ip = target[IP_W-1:0];
                            n_out = pack(target[IP_W-1:0], ov, oc, 1'b0, '0, ST_OK);
                        end
                    end
                    n_oval = 1'b1;
                    n_state = (st != ST_OK) ? S_HALT : S_IDLE;
                end
            end
            S_OUT: begin
                n_oval = 1'b1;
                n_state = S_HALT;
            end
            S_HALT: begin
                n_state = S_HALT;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### rtl/sme_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### tb/stack_machine_execute_test.sv
// Self-checking testbench for stack_machine_execute: drives instruction beats,
// predicts each result in-bench and compares it field by field.
// Depends on sme_pkg and the stack_machine_execute RTL.
`timescale 1ns / 1ps
module stack_machine_execute_test;
    import sme_pkg::*;

    localparam logic [1:0]  REG_PROG_LEN  = 2'd0;
    localparam logic [31:0] INT_MIN       = 32'h8000_0000;
    localparam int          STALL_LIMIT   = 5000;
    localparam int          SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [11:0] next_ip;
        logic        out_valid;
        logic [6:0]  out_char;
        logic        finished;
        logic [31:0] return_value;
        t_status     status;
    } t_exec_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // req_type[4:0], immediate[36:5], in_char[45:37]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // next_ip[11:0], out_valid[12], out_char[19:13],
                                      // finished[20], return_value[52:21], status[55:53]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    stack_machine_execute dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // machine state mirrored by the predictor
    logic [31:0]  stk [0:STACK_DEPTH-1];
    int unsigned  depth = 0;
    logic [11:0]  ip = '0;
    bit           halted = 1'b0;
    logic [12:0]  plen = PROG_LEN_RESET;

    t_exec_result pending_results[$];
    int           fails = 0;
    int           send_idle = 0;
    int           recv_stall = 0;
    int           quiet_cycles = 0;

    function automatic int unsigned ip_limit();
        return (plen > PROGRAM_DEPTH) ? PROGRAM_DEPTH : plen;
    endfunction

    function automatic int unsigned pops_of(logic [4:0] op);
        case (op)
            OP_IN, OP_PUSH: return 0;
            OP_OUT, OP_NOT, OP_LNOT, OP_NEG, OP_JMP, OP_POP, OP_DUP, OP_RET: return 1;
            default: return 2;
        endcase
    endfunction

    task automatic execute_instr(input logic [4:0] op, input logic [31:0] imm,
                                 input logic [8:0] ch);
        int unsigned  lim;
        int unsigned  need;
        bit           grow;
        bit           has_val;
        bit           jump;
        logic [31:0]  x;
        logic [31:0]  y;
        logic [31:0]  val;
        logic [31:0]  tgt;
        t_status      st;
        t_exec_result r;
        if (halted) return;
        lim = ip_limit();
        r = '0;
        st = ST_OK;
        tgt = {20'd0, ip} + 32'd1;
        jump = 1'b0;
        has_val = 1'b0;
        x = '0;
        y = '0;
        val = '0;
        if (ip >= lim) begin
            st = ST_IPRANGE;
        end else if (op > OP_RET) begin
            st = ST_OPCODE;
        end else begin
            need = pops_of(op);
            grow = (op == OP_IN || op == OP_PUSH || op == OP_DUP);
            if (depth < need) begin
                st = ST_UNDER;
            end else if (grow && depth >= STACK_DEPTH) begin
                st = ST_OVER;
            end else begin
                if (need >= 1) x = stk[depth-1];
                if (need >= 2) y = stk[depth-2];
                has_val = 1'b1;
                case (t_op'(op))
                    OP_IN:   val = {{23{ch[8]}}, ch};
                    OP_OUT: begin
                        if (x > 127) begin
                            st = ST_ASCII;
                        end else begin
                            r.out_valid = 1'b1;
                            r.out_char = x[6:0];
                            has_val = 1'b0;
                        end
                    end
                    OP_ADD:  val = x + y;
                    OP_SUB:  val = x - y;
                    OP_MUL:  val = x * y;
                    OP_DIV: begin
                        if (x == 0) st = ST_DIVZERO;
                        else if (y == INT_MIN && x == '1) val = INT_MIN;
                        else val = $signed(y) / $signed(x);
                    end
                    OP_MOD: begin
                        if (y == 0) st = ST_DIVZERO;
                        else if (x == INT_MIN && y == '1) val = '0;
                        else val = $signed(x) % $signed(y);
                    end
                    OP_AND:  val = x & y;
                    OP_OR:   val = x | y;
                    OP_XOR:  val = x ^ y;
                    OP_NOT:  val = ~x;
                    OP_LNOT: val = (x == 0) ? 32'd1 : 32'd0;
                    OP_NEG:  val = -x;
                    OP_SHR:  val = $signed(y) >>> x[4:0];
                    OP_SHL:  val = y << x[4:0];
                    OP_JMP: begin
                        tgt = x;
                        jump = 1'b1;
                        has_val = 1'b0;
                    end
                    OP_BR: begin
                        if (y != 0) begin
                            tgt = x;
                            jump = 1'b1;
                        end
                        has_val = 1'b0;
                    end
                    OP_PUSH: val = imm;
                    OP_POP:  has_val = 1'b0;
                    OP_DUP:  val = x;
                    default: begin
                        r.finished = 1'b1;
                        r.return_value = x;
                        has_val = 1'b0;
                    end
                endcase
                if (st == ST_OK) begin
                    depth -= need;
                    if (op == OP_DUP) depth += 1;
                    if (has_val) begin
                        stk[depth] = val;
                        depth += 1;
                    end
                    if (r.finished) halted = 1'b1;
                    else if ((jump && tgt[31]) || tgt >= lim) st = ST_IPRANGE;
                    else ip = tgt[11:0];
                end
            end
        end
        if (st != ST_OK) begin
            halted = 1'b1;
            if (st != ST_IPRANGE) begin
                r.out_valid = 1'b0;
                r.out_char = '0;
            end
        end
        r.next_ip = ip;
        r.status = st;
        pending_results.push_back(r);
    endtask

    // Send one instruction beat; called at a rising edge, returns at its accept edge.
    task automatic issue(input logic [4:0] op, input logic [31:0] imm = '0,
                         input logic [8:0] ch = '0);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, ch, imm, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        execute_instr(op, imm, ch);
    endtask

    task automatic jump_to(input logic [31:0] tgt);
        issue(OP_PUSH, tgt);
        issue(OP_JMP);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_prog_len(input logic [31:0] v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_PROG_LEN;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        plen = v[12:0];
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {19'd0, v[12:0]}) begin
            $error("program_length: expected %0d, got %0d", v[12:0], prdata);
            fails++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(3))
            0, 1:    return $urandom;
            2:       return $urandom_range(127);
            default: return $urandom_range(ip_limit() - 1);
        endcase
    endfunction

    function automatic logic [8:0] rand_char();
        return ($urandom_range(7) == 0) ? 9'h1FF : 9'($urandom_range(255));
    endfunction

    // Well-formed draw: push where it would halt, pop where it would grow past depth 48.
    // Jump targets stay under the limit minus two so a push and a jump always fit after.
    task automatic random_instr();
        logic [4:0]  op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] fill;
        int unsigned lim;
        bit          ok;
        lim = ip_limit();
        if (ip + 2 >= lim) begin
            jump_to($urandom_range(lim - 3));
            return;
        end
        op = 5'($urandom_range(OP_DUP));
        x = (depth >= 1) ? stk[depth-1] : '0;
        y = (depth >= 2) ? stk[depth-2] : '0;
        ok = 1'b1;
        if (depth < pops_of(op)) ok = 1'b0;
        else if (depth >= 48 && (op == OP_IN || op == OP_PUSH || op == OP_DUP)) op = OP_POP;
        else begin
            case (op)
                OP_OUT: ok = (x <= 127);
                OP_DIV: ok = (x != 0);
                OP_MOD: ok = (y != 0);
                OP_JMP: ok = (x < lim - 2);
                OP_BR:  ok = (y == 0) || (x < lim - 2);
                default: ok = 1'b1;
            endcase
        end
        if (ok) begin
            issue(op, rand_operand(), rand_char());
        end else begin
            if (op == OP_OUT) fill = $urandom_range(127);
            else if (op == OP_JMP || op == OP_BR) fill = $urandom_range(lim - 3);
            else fill = rand_operand();
            issue(OP_PUSH, fill);
        end
    endtask

    task automatic test_directed();
        issue(OP_IN, '0, 9'h1FF);
        issue(OP_IN, '0, 9'd255);
        issue(OP_ADD);
        issue(OP_PUSH, INT_MIN);
        issue(OP_PUSH, 32'hFFFF_FFFF);
        issue(OP_DIV);                      // minimum over minus one
        issue(OP_PUSH, 32'hFFFF_FFFF);
        issue(OP_PUSH, INT_MIN);
        issue(OP_MOD);                      // remainder of that case is zero
        issue(OP_LNOT);
        issue(OP_SUB);
        issue(OP_PUSH, 32'd33);             // shift amount wraps to its low 5 bits
        issue(OP_SHL);
        issue(OP_PUSH, 32'd31);
        issue(OP_SHR);
        issue(OP_MUL);
        issue(OP_PUSH, 32'h7FFF_FFFF);
        issue(OP_AND);
        issue(OP_PUSH, 32'd5);
        issue(OP_OR);
        issue(OP_PUSH, 32'd3);
        issue(OP_XOR);
        issue(OP_NOT);
        issue(OP_NEG);
        issue(OP_DUP);
        issue(OP_POP);
        issue(OP_PUSH, 32'd127);
        issue(OP_OUT);
        issue(OP_PUSH, 32'd0);
        issue(OP_OUT);
        issue(OP_PUSH, 32'd0);
        issue(OP_PUSH, 32'd50);
        issue(OP_BR);                       // not taken
        issue(OP_PUSH, 32'd1);
        issue(OP_PUSH, 32'd0);
        issue(OP_BR);                       // taken back to address zero
    endtask

    task automatic test_random(input int n);
        repeat (n) random_instr();
    endtask

    task automatic test_prog_len();
        write_prog_len(32'd8191);
        test_random(30);
        // park at address zero with zeros on the stack, then run at length one
        jump_to(32'd0);
        repeat (3) issue(OP_PUSH, 32'd0);
        jump_to(32'd0);
        write_prog_len(32'd1);
        repeat (3) issue(OP_JMP);
        write_prog_len(32'd4096);
        test_random(20);
        // park at address zero so the shorter program still holds the pointer
        jump_to(32'd0);
        write_prog_len($urandom_range(200, 4000));
    endtask

    task automatic test_sender_pause();
        test_random(20);
        drain();
        test_random(20);
    endtask

    // Finish with one halting case, picked at random.
    task automatic test_halt();
        logic [31:0] lim;
        write_prog_len(32'd4096);
        lim = ip_limit();
        jump_to(32'd5);
        case ($urandom_range(9))
            0: begin
                issue(OP_PUSH, $urandom);
                issue(OP_RET);
            end
            1: begin
                issue(OP_PUSH, 32'd3);
                issue(OP_PUSH, 32'd0);
                issue(OP_DIV);
            end
            2: begin
                issue(OP_PUSH, 32'd0);
                issue(OP_PUSH, 32'd3);
                issue(OP_MOD);
            end
            3: issue(5'($urandom_range(21, 31)));
            4: begin
                issue(OP_PUSH, $urandom_range(128, 32'hFFFF_FFFF));
                issue(OP_OUT);
            end
            5: begin
                issue(OP_PUSH, 32'hFFFF_FFFF);
                issue(OP_JMP);
            end
            6: begin
                while (depth != 0) issue(OP_POP);
                issue(($urandom_range(1) == 0) ? OP_RET : OP_DUP);
            end
            7: begin
                jump_to(lim - 1);
                issue(OP_PUSH, $urandom);
            end
            8: begin
                write_prog_len(32'd1);
                issue(OP_PUSH, $urandom);
            end
            default: begin
                while (depth < STACK_DEPTH) begin
                    if (ip + 2 >= lim) jump_to(32'd0);
                    else issue(OP_PUSH, $urandom);
                end
                issue(($urandom_range(1) == 0) ? OP_DUP : OP_IN, $urandom, rand_char());
            end
        endcase
    endtask

    // result side: random stall and compare against the oldest expectation
    always @(posedge i_clk) begin
        t_exec_result got;
        t_exec_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{next_ip: m_axis_tdata[11:0], out_valid: m_axis_tdata[12],
                        out_char: m_axis_tdata[19:13], finished: m_axis_tdata[20],
                        return_value: m_axis_tdata[52:21],
                        status: t_status'(m_axis_tdata[55:53])};
                if (pending_results.size() == 0) begin
                    $error("result beat with no expectation pending: %h", m_axis_tdata);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.next_ip !== want.next_ip) begin
                        $error("next_ip: expected %0d, got %0d", want.next_ip, got.next_ip);
                        fails++;
                    end
                    if (got.out_valid !== want.out_valid) begin
                        $error("out_valid: expected %0d, got %0d",
                               want.out_valid, got.out_valid);
                        fails++;
                    end
                    if (got.out_char !== want.out_char) begin
                        $error("out_char: expected %0d, got %0d", want.out_char, got.out_char);
                        fails++;
                    end
                    if (got.finished !== want.finished) begin
                        $error("finished: expected %0d, got %0d", want.finished, got.finished);
                        fails++;
                    end
                    if (got.return_value !== want.return_value) begin
                        $error("return_value: expected %h, got %h",
                               want.return_value, got.return_value);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                end
            end
        end
    end

    // watchdog: count cycles in which no beat and no register access completes
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_prog_len();
        send_idle = 0;
        recv_stall = 0;
        test_random(180);
        send_idle = 58;
        test_random(180);
        send_idle = 0;
        recv_stall = 58;
        test_sender_pause();
        test_random(140);
        send_idle = 37;
        recv_stall = 37;
        test_random(180);
        test_halt();
        drain();
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fails++;
        end
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

### sim.f
rtl/sme_pkg.sv
rtl/sme_ram.sv
rtl/stack_machine_execute.sv
tb/stack_machine_execute_test.sv
